FILE: hw/rtl/halfstep_stepper_position_controller_assert.svh
// Assertion helpers shared by the stepper controller modules.
`ifndef HALFSTEP_STEPPER_POSITION_CONTROLLER_ASSERT_SVH
`define HALFSTEP_STEPPER_POSITION_CONTROLLER_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define HSSP_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hssp: same-cycle check failed");

// Next-cycle implication, switched off while reset is high.
`define HSSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hssp: next-cycle check failed");

`endif

FILE: hw/rtl/hssp_pkg.sv
package hssp_pkg;

  localparam int ANGLE_W   = 16;
  localparam int TARGET_W  = 17;
  localparam int PERIOD_W  = 24;
  localparam int SPR_W     = 16;
  localparam int COUNT_W   = 15;
  localparam int PHASE_W   = 3;
  localparam int COILS_W   = 4;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 24;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 24'd2000;
  localparam logic [SPR_W-1:0]    SPR_RESET    = 16'd4096;
  localparam logic [PERIOD_W-1:0] ELAPSED_MAX  = 24'hFFFFFF;

  // A full turn of 36000 is 32 * 1125: the divide shifts out the power of two
  // and handles the odd factor with a reciprocal multiply and one correction.
  localparam logic [15:0] RECIP_MULT = 16'd59652;
  localparam logic [10:0] DIV_ODD    = 11'd1125;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_MOVE = 1'b1
  } op_t;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_PERIOD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEPS_REV   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_MODE    = 8'd2;

  typedef struct packed {
    logic                       start;
    logic                       ack;
    logic signed [TARGET_W-1:0] target;
    logic [ANGLE_W-1:0]         cur_angle;
    logic [SPR_W-1:0]           spr;
  } mv_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [COUNT_W-1:0] steps;
    logic               backward;
    logic [ANGLE_W-1:0] angle;
  } mv_rsp_t;

  // Half-step sequence A, AB, B, BC, C, CD, D, DA.
  function automatic logic [COILS_W-1:0] coil_pattern(input logic [PHASE_W-1:0] ph);
    logic [COILS_W-1:0] pat;
    case (ph)
      3'd0: pat = 4'b0001;
      3'd1: pat = 4'b0011;
      3'd2: pat = 4'b0010;
      3'd3: pat = 4'b0110;
      3'd4: pat = 4'b0100;
      3'd5: pat = 4'b1100;
      3'd6: pat = 4'b1000;
      3'd7: pat = 4'b1001;
      default: pat = 4'b0001;
    endcase
    return pat;
  endfunction

endpackage

FILE: hw/rtl/hssp_move_unit.sv
`include "halfstep_stepper_position_controller_assert.svh"

module hssp_move_unit import hssp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  mv_req_t req,
  output mv_rsp_t rsp
);

  typedef enum logic [4:0] {
    MV_IDLE  = 5'b00001,
    MV_PROD  = 5'b00010,
    MV_RECIP = 5'b00100,
    MV_FIX   = 5'b01000,
    MV_DONE  = 5'b10000
  } mv_state_t;

  mv_state_t state;

  logic signed [17:0] tgt_ext;
  logic signed [17:0] norm;
  logic signed [17:0] diff;
  logic signed [17:0] wrapped;
  logic signed [17:0] mag_abs;

  logic [COUNT_W-1:0] mag;
  logic               backward;
  logic [ANGLE_W-1:0] angle;
  logic [30:0]        prod;
  logic [25:0]        y_reg;
  logic [COUNT_W-1:0] est;
  logic [COUNT_W-1:0] quot;

  logic [30:0] prod_full;
  logic [41:0] recip_full;
  logic [26:0] est_x;
  logic [26:0] y_ext;
  logic [26:0] rem;
  logic [26:0] chk_prod;
  logic [26:0] odd_ext;

  // Bring the target into 0..35999, then take the shortest way round.
  always_comb begin
    tgt_ext = {req.target[TARGET_W-1], req.target};
    if (tgt_ext >= 18'sd36000) begin
      norm = tgt_ext - 18'sd36000;
    end else if (tgt_ext >= 18'sd0) begin
      norm = tgt_ext;
    end else if (tgt_ext >= -18'sd36000) begin
      norm = tgt_ext + 18'sd36000;
    end else begin
      norm = tgt_ext + 18'sd72000;
    end
    diff = norm - $signed({2'b00, req.cur_angle});
    if (diff > 18'sd18000) begin
      wrapped = diff - 18'sd36000;
    end else if (diff < -18'sd18000) begin
      wrapped = diff + 18'sd36000;
    end else begin
      wrapped = diff;
    end
    mag_abs = wrapped[17] ? -wrapped : wrapped;
  end

  assign prod_full  = {16'd0, mag} * {15'd0, req.spr};
  assign recip_full = {16'd0, prod[30:5]} * {26'd0, RECIP_MULT};
  assign odd_ext    = {16'd0, DIV_ODD};
  assign est_x      = {12'd0, est} * odd_ext;
  assign y_ext      = {1'b0, y_reg};
  assign rem        = y_ext - est_x;
  assign chk_prod   = {12'd0, quot} * odd_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MV_IDLE;
    end else begin
      case (state)
        MV_IDLE:  if (req.start) state <= MV_PROD;
        MV_PROD:  state <= MV_RECIP;
        MV_RECIP: state <= MV_FIX;
        MV_FIX:   state <= MV_DONE;
        MV_DONE:  if (req.ack) state <= MV_IDLE;
        default:  state <= MV_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == MV_IDLE && req.start) begin
      mag      <= mag_abs[COUNT_W-1:0];
      backward <= wrapped[17];
      angle    <= norm[ANGLE_W-1:0];
    end
    if (state == MV_PROD) begin
      prod <= prod_full;
    end
    if (state == MV_RECIP) begin
      y_reg <= prod[30:5];
      est   <= recip_full[40:26];
    end
    if (state == MV_FIX) begin
      quot <= (rem >= odd_ext) ? est + 15'd1 : est;
    end
  end

  assign rsp.busy     = (state != MV_IDLE);
  assign rsp.done     = (state == MV_DONE);
  assign rsp.steps    = quot;
  assign rsp.backward = backward;
  assign rsp.angle    = angle;

  `HSSP_ASSERT_IMPLIES(a_quotient_exact, clk, rst, state == MV_DONE, (chk_prod <= y_ext) && ((y_ext - chk_prod) < odd_ext))

endmodule

FILE: hw/rtl/halfstep_stepper_position_controller.sv
// Channel  | Handshake              | Payload
// ---------+------------------------+---------------------------------------------
// command  | cmd_valid / cmd_stall  | op, target_angle
// result   | res_valid / res_stall  | coils, phase, stepped, busy_res, steps_done,
//          |                        | angle_now
// config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A tick beat passes from the command register through the step logic into the
// result register, so ticks flow at one per clock while the result is not stalled.
// A move beat that starts a move is held while the move unit runs its normalise,
// multiply, reciprocal and correction stages; an ignored move goes straight to a result.
// Reset (rst, synchronous) clears all motion state and loads the register defaults.
// A stalled result holds the result register; one further command beat is still
// taken into the command register, after which cmd_stall rises.
// Configuration writes are always ready and take effect on the next cycle.

`include "halfstep_stepper_position_controller_assert.svh"

module halfstep_stepper_position_controller import hssp_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  output logic                       cmd_stall,
  input  logic                       op,
  input  logic signed [TARGET_W-1:0] target_angle,
  output logic                       res_valid,
  input  logic                       res_stall,
  output logic [COILS_W-1:0]         coils,
  output logic [PHASE_W-1:0]         phase,
  output logic                       stepped,
  output logic                       busy_res,
  output logic [COUNT_W-1:0]         steps_done,
  output logic [ANGLE_W-1:0]         angle_now,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DAT_W-1:0]       cfg_data
);

  // Configuration registers.
  logic [PERIOD_W-1:0] step_period_us;
  logic [SPR_W-1:0]    steps_per_rev;
  logic                run_mode;

  // Motion state.
  logic [PHASE_W-1:0]  phase_index;
  logic [ANGLE_W-1:0]  current_angle;
  logic [PERIOD_W-1:0] elapsed_us;
  logic [COUNT_W-1:0]  steps_left;
  logic [COUNT_W-1:0]  steps_taken;
  logic                move_backward;

  logic [PHASE_W-1:0]  phase_next;
  logic [ANGLE_W-1:0]  angle_next;
  logic [PERIOD_W-1:0] elapsed_next;
  logic [COUNT_W-1:0]  left_next;
  logic [COUNT_W-1:0]  taken_next;
  logic                backward_next;
  logic                stepped_next;

  // Command register.
  logic                       cmd_held;
  op_t                        op_reg;
  logic signed [TARGET_W-1:0] target_reg;

  logic cmd_accept;
  logic res_free;
  logic is_tick;
  logic is_move;
  logic move_skip;
  logic move_start;
  logic move_finish;
  logic consume;

  logic [PERIOD_W-1:0] elapsed_inc;
  logic                due;
  logic                left_nz;
  logic                step_now;
  logic [PHASE_W-1:0]  phase_adv;

  mv_req_t mv_req;
  mv_rsp_t mv_rsp;

  // The configuration port never pushes back; writes should arrive only while idle (not enforced here).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_period_us <= PERIOD_RESET;
      steps_per_rev  <= SPR_RESET;
      run_mode       <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STEP_PERIOD: step_period_us <= cfg_data;
        REG_STEPS_REV:   steps_per_rev  <= cfg_data[SPR_W-1:0];
        REG_RUN_MODE:    run_mode       <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // The result register may be loaded when it is empty or being emptied.
  assign res_free = !res_valid || !res_stall;

  assign is_tick = cmd_held && (op_reg == OP_TICK);
  assign is_move = cmd_held && (op_reg == OP_MOVE);

  // A move that finds steps still pending is dropped, but still gives a result.
  assign left_nz     = (steps_left != '0);
  assign move_skip   = is_move && left_nz && !mv_rsp.busy;
  assign move_start  = is_move && !left_nz && !mv_rsp.busy;
  assign move_finish = is_move && mv_rsp.done;

  assign consume    = res_free && (is_tick || move_skip || move_finish);
  assign cmd_stall  = cmd_held && !consume;
  assign cmd_accept = cmd_valid && !cmd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_held <= 1'b0;
    end else if (cmd_accept) begin
      cmd_held <= 1'b1;
    end else if (consume) begin
      cmd_held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_accept) begin
      op_reg     <= op_t'(op);
      target_reg <= target_angle;
    end
  end

  // The move unit turns a target angle into a direction and a step count.
  assign mv_req.start     = move_start;
  assign mv_req.ack       = res_free && mv_rsp.done;
  assign mv_req.target    = target_reg;
  assign mv_req.cur_angle = current_angle;
  assign mv_req.spr       = steps_per_rev;

  hssp_move_unit u_move (
    .clk (clk),
    .rst (rst),
    .req (mv_req),
    .rsp (mv_rsp)
  );

  // The elapsed counter saturates rather than wrapping, so a long pause never
  // delays the first step of a later move.
  assign elapsed_inc = (elapsed_us == ELAPSED_MAX) ? elapsed_us : elapsed_us + 24'd1;
  assign due         = (elapsed_inc >= step_period_us);
  assign step_now    = due && (run_mode || left_nz);
  // Continuous rotation always runs forwards; a positional move follows its direction.
  assign phase_adv   = (!run_mode && move_backward) ? phase_index - 3'd1
                                                    : phase_index + 3'd1;

  always_comb begin
    phase_next    = phase_index;
    angle_next    = current_angle;
    elapsed_next  = elapsed_us;
    left_next     = steps_left;
    taken_next    = steps_taken;
    backward_next = move_backward;
    stepped_next  = 1'b0;
    if (is_tick) begin
      elapsed_next = step_now ? '0 : elapsed_inc;
      stepped_next = step_now;
      if (step_now) begin
        phase_next = phase_adv;
      end
      if (due && !run_mode && left_nz) begin
        left_next  = steps_left - 15'd1;
        taken_next = steps_taken + 15'd1;
      end
    end else if (move_finish) begin
      left_next     = mv_rsp.steps;
      taken_next    = '0;
      backward_next = mv_rsp.backward;
      angle_next    = mv_rsp.angle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_index   <= '0;
      current_angle <= '0;
      elapsed_us    <= '0;
      steps_left    <= '0;
      steps_taken   <= '0;
      move_backward <= 1'b0;
    end else if (consume) begin
      phase_index   <= phase_next;
      current_angle <= angle_next;
      elapsed_us    <= elapsed_next;
      steps_left    <= left_next;
      steps_taken   <= taken_next;
      move_backward <= backward_next;
    end
  end

  // Result register: every consumed command beat produces exactly one result beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (consume) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume) begin
      coils      <= coil_pattern(phase_next);
      phase      <= phase_next;
      stepped    <= stepped_next;
      busy_res   <= (left_next != '0);
      steps_done <= taken_next;
      angle_now  <= angle_next;
    end
  end

  `HSSP_ASSERT_IMPLIES(a_move_blocks_cmd, clk, rst, mv_rsp.busy && !mv_rsp.done, cmd_stall)
  `HSSP_ASSERT_NEXT(a_phase_holds, clk, rst, consume && !stepped_next, phase_index == $past(phase_index))
  `HSSP_ASSERT_NEXT(a_step_clears_time, clk, rst, consume && stepped_next, elapsed_us == 24'd0)

endmodule
